// File: rtl/core/lfsa_pkg.sv
// Shared types, constants and a helper function for the lowest free seat allocator.
// No dependencies; every other file in rtl/core imports this package.
package lfsa_pkg;

  // Seat count; client ids always cover the full id space
  localparam int unsigned NumSeats   = 64;
  localparam int unsigned ClientW    = 6;
  localparam int unsigned SeatW      = 6;
  localparam int unsigned NumClients = 1 << ClientW;
  localparam int unsigned MapW       = 1 << SeatW;

  // Seats that exist: the low NumSeats bits of the free map
  localparam logic [MapW-1:0] SeatMask =
    (NumSeats >= MapW) ? {MapW{1'b1}} : ((MapW'(1) << NumSeats) - MapW'(1));

  typedef enum logic [0:0] {
    ReqArrive = 1'b0,
    ReqLeave  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    StSeated    = 2'd0,
    StFreed     = 2'd1,
    StNoSeat    = 2'd2,
    StNotSeated = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    FsmIdle = 1'b0,
    FsmExec = 1'b1
  } fsm_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [ClientW-1:0] client_id;
  } lfsa_req_t;

  typedef struct packed {
    logic [SeatW-1:0] seat;
    status_e          status;
    logic             is_target;
  } lfsa_res_t;

  // Access bundle toward the seat table
  typedef struct packed {
    logic               rd_en;
    logic [ClientW-1:0] rd_addr;
    logic               wr_en;
    logic [ClientW-1:0] wr_addr;
    logic [SeatW-1:0]   wr_data;
  } seat_mem_req_t;

  // Two-level priority encoder: first nonzero byte, then first bit in it
  function automatic logic [SeatW-1:0] lowest_set(input logic [MapW-1:0] v);
    logic [7:0] grp_any;
    logic [2:0] grp;
    logic [7:0] sel;
    logic [2:0] bit_idx;
    for (int i = 0; i < 8; i++) begin
      grp_any[i] = |v[i*8 +: 8];
    end
    grp = '0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_any[i]) grp = 3'(i);
    end
    sel = v[{grp, 3'b000} +: 8];
    bit_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (sel[i]) bit_idx = 3'(i);
    end
    return {grp, bit_idx};
  endfunction

endpackage

// File: rtl/core/lfsa_seat_mem.sv
// Seat table: one seat number per client, synchronous registered read.
// Depends on lfsa_pkg for widths and the access bundle type.
module lfsa_seat_mem (
  input  logic                   clk_i,
  input  lfsa_pkg::seat_mem_req_t mem_req_i,
  output logic [lfsa_pkg::SeatW-1:0] rdata_o
);
  import lfsa_pkg::*;

  logic [SeatW-1:0] mem_q [NumClients];
  logic [SeatW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd_en) begin
      rdata_q <= mem_q[mem_req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/lfsa_core.sv
// Request sequencer: free-seat and seated-client maps, table read-modify-write.
// Depends on lfsa_pkg; drives the seat table in lfsa_seat_mem.
module lfsa_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lfsa_pkg::lfsa_req_t          in_req_i,
  input  logic [lfsa_pkg::ClientW-1:0] target_client_i,
  input  logic                         res_free_i,
  output logic                         res_valid_o,
  output lfsa_pkg::lfsa_res_t          res_o,
  output lfsa_pkg::seat_mem_req_t      mem_req_o,
  input  logic [lfsa_pkg::SeatW-1:0]   mem_rdata_i
);
  import lfsa_pkg::*;

  fsm_e                 state_q, state_d;
  lfsa_req_t            req_q, req_d;
  logic [MapW-1:0]      free_q, free_d;
  logic [NumClients-1:0] seated_q, seated_d;

  logic                 accept;
  logic                 finish;
  logic [ClientW-1:0]   cid;
  logic                 is_seated;
  logic [MapW-1:0]      avail;
  logic [SeatW-1:0]     low_seat;

  assign accept    = (state_q == FsmIdle) && in_valid_i;
  assign finish    = (state_q == FsmExec) && res_free_i;
  assign cid       = req_q.client_id;
  assign is_seated = seated_q[cid];
  assign avail     = free_q & SeatMask;
  assign low_seat  = lowest_set(avail);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle: if (in_valid_i) state_d = FsmExec;
      FsmExec: if (res_free_i) state_d = FsmIdle;
      default: state_d = FsmIdle;
    endcase
  end

  // Outputs and map updates
  always_comb begin
    in_stall_o        = (state_q != FsmIdle);
    req_d             = accept ? in_req_i : req_q;
    free_d            = free_q;
    seated_d          = seated_q;
    res_valid_o       = finish;
    res_o.seat        = '0;
    res_o.status      = StNotSeated;
    res_o.is_target   = 1'b0;
    mem_req_o.rd_en   = accept;
    mem_req_o.rd_addr = in_req_i.client_id;
    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = cid;
    mem_req_o.wr_data = low_seat;

    // Resolve the held request against the maps and the table read data
    if (req_q.req_type == ReqArrive) begin
      if (is_seated) begin
        res_o.seat   = mem_rdata_i;
        res_o.status = StSeated;
      end else if (avail == '0) begin
        res_o.status = StNoSeat;
      end else begin
        res_o.seat   = low_seat;
        res_o.status = StSeated;
        if (finish) begin
          free_d[low_seat] = 1'b0;
          seated_d[cid]    = 1'b1;
          mem_req_o.wr_en  = 1'b1;
        end
      end
      res_o.is_target = (res_o.status == StSeated) && (cid == target_client_i);
    end else begin
      if (is_seated) begin
        res_o.seat   = mem_rdata_i;
        res_o.status = StFreed;
        if (finish) begin
          free_d[mem_rdata_i] = 1'b1;
          seated_d[cid]       = 1'b0;
        end
      end
    end
  end

  // Control state and maps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FsmIdle;
      free_q   <= SeatMask;
      seated_q <= '0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      seated_q <= seated_d;
    end
  end

  // Held request
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule

// File: rtl/core/lowest_free_seat_allocator.sv
// Lowest free seat allocator: top level with the target register and result register.
// Depends on lfsa_pkg, lfsa_core and lfsa_seat_mem.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) carries one arrive or
//   leave request. Output channel (out_valid_o / out_stall_i / out_res_o)
//   returns exactly one result per request: seat, status and target flag.
//   The target client register is written through cfg_valid_i / cfg_ready_o /
//   cfg_data_i; it is always ready and should only be written while idle.
// Timing:
//   The sequencer handles one request at a time and stalls the input while busy.
//   In its idle state it accepts a request and issues the seat table read; in
//   its execute state it does the map update, table write-back and result load.
// Reset:
//   All seats free, no client seated, target client 0. The seat table needs
//   no clearing; its read data is only used for a client that is seated.
// Stall:
//   A stalled result holds in the output register; the sequencer still takes
//   the next request and waits in its execute state until the register frees.
module lowest_free_seat_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lfsa_pkg::lfsa_req_t          in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lfsa_pkg::lfsa_res_t          out_res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfsa_pkg::ClientW-1:0] cfg_data_i
);
  import lfsa_pkg::*;

  logic [ClientW-1:0] target_q, target_d;
  logic               out_valid_q, out_valid_d;
  lfsa_res_t          out_res_q, out_res_d;

  logic               res_free;
  logic               res_valid;
  lfsa_res_t          res;
  seat_mem_req_t      mem_req;
  logic [SeatW-1:0]   mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign res_free    = !out_valid_q || !out_stall_i;

  // Target client register
  assign target_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : target_q;

  // Result register: load a new result, drop one that was taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      target_q    <= target_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  lfsa_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_req_i        (in_req_i),
    .target_client_i (target_q),
    .res_free_i      (res_free),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata)
  );

  lfsa_seat_mem u_seat_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

endmodule
